// ===== hw/rtl/tbq_pkg.sv =====
// Shared constants and types of the two-bit quantizer and packer.
package tbq_pkg;

  localparam int MaxChannelsDefault = 64;
  localparam int SampleWidthDefault = 16;

  localparam int CfgDataWidth  = 24;
  localparam int CfgIndexWidth = 2;

  localparam logic [1:0] REG_THRESHOLD_SCALE  = 2'd0;
  localparam logic [1:0] REG_CHANNELS_LOG2    = 2'd1;
  localparam logic [1:0] REG_STATS_LIMIT      = 2'd2;
  localparam logic [1:0] REG_WORDS_PER_PACKET = 2'd3;

  localparam logic [1:0] CODE_HIGH_NEG = 2'd0;
  localparam logic [1:0] CODE_LOW_NEG  = 2'd1;
  localparam logic [1:0] CODE_LOW_POS  = 2'd2;
  localparam logic [1:0] CODE_HIGH_POS = 2'd3;

  localparam logic [15:0] RMS_RESET   = 16'd4096;
  localparam int          PowerWidth  = 56;
  localparam int          CountWidth  = 24;
  localparam int          RmsWidth    = 16;
  localparam logic [4:0]  LAST_SLOT   = 5'd31;
  localparam logic [10:0] PACKET_MAX  = 11'd1024;

  // Status from the statistics unit to the top level.
  typedef struct packed {
    logic busy;
    logic ready;
  } tbq_stat_t;

endpackage

// ===== hw/rtl/tbq_if.sv =====
// Valid/ready channel interface carrying one word of payload.
interface tbq_if #(
  parameter int Width = 16
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tbq_divsqrt.sv =====
// Sequential divider followed by a sequential integer square root.
module tbq_divsqrt
  import tbq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PowerWidth-1:0] dividend,
  input  logic [CountWidth-1:0] divisor,
  output logic                  done,
  output logic [RmsWidth-1:0]   root
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SQRT, S_DONE} dstate_t;

  dstate_t               state;
  logic [PowerWidth-1:0] quo;
  logic [CountWidth:0]   rem;
  logic [CountWidth-1:0] den;
  logic [5:0]            step;
  logic [PowerWidth-1:0] sq_val;
  logic [PowerWidth-1:0] sq_rem;
  logic [PowerWidth/2:0] sq_root;
  logic [CountWidth:0]   rem_shift;
  logic [PowerWidth+1:0] trial;
  logic [PowerWidth+1:0] sq_rem_shift;

  always_comb begin
    rem_shift    = {rem[CountWidth-1:0], quo[PowerWidth-1]};
    sq_rem_shift = {sq_rem, sq_val[PowerWidth-1 -: 2]};
    trial        = {{(PowerWidth/2 - 1){1'b0}}, sq_root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            quo   <= dividend;
            den   <= divisor;
            rem   <= '0;
            step  <= 6'(PowerWidth - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // One restoring division step per cycle, quotient shifts in from the bottom.
          if (rem_shift >= {1'b0, den}) begin
            rem <= rem_shift - {1'b0, den};
            quo <= {quo[PowerWidth-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[PowerWidth-2:0], 1'b0};
          end
          if (step == 6'd0) begin
            state <= S_SQRT;
          end else begin
            step <= step - 6'd1;
          end
        end
        S_SQRT: begin
          if (step == 6'd0) begin
            sq_val  <= quo;
            sq_rem  <= '0;
            sq_root <= '0;
            step    <= 6'd1;
          end else begin
            // Two radicand bits per cycle.
            sq_val <= {sq_val[PowerWidth-3:0], 2'b00};
            if (sq_rem_shift >= trial) begin
              sq_rem  <= PowerWidth'(sq_rem_shift - trial);
              sq_root <= {sq_root[PowerWidth/2-1:0], 1'b1};
            end else begin
              sq_rem  <= PowerWidth'(sq_rem_shift);
              sq_root <= {sq_root[PowerWidth/2-1:0], 1'b0};
            end
            if (step == 6'(PowerWidth / 2)) begin
              state <= S_DONE;
            end
            step <= step + 6'd1;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The root of a 56-bit value fits in 28 bits; saturate to the rms width.
  assign root = (|sq_root[PowerWidth/2:RmsWidth]) ? {RmsWidth{1'b1}} : sq_root[RmsWidth-1:0];

endmodule

// ===== hw/rtl/tbq_stats.sv =====
// Per-channel statistics and rms memories with a read-modify-write pipeline.
module tbq_stats
  import tbq_pkg::*;
#(
  parameter int MaxChannels = MaxChannelsDefault,
  parameter int SampleWidth = SampleWidthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           smp_valid,
  input  logic [$clog2(MaxChannels)-1:0] smp_ch,
  input  logic signed [SampleWidth-1:0]  smp_data,
  input  logic                           smp_eos,
  input  logic [$clog2(MaxChannels):0]   active_n,
  input  logic [CountWidth-1:0]          stats_limit,
  output logic [RmsWidth-1:0]            rms_out,
  output tbq_stat_t                      stat
);

  localparam int ChW = $clog2(MaxChannels) > 0 ? $clog2(MaxChannels) : 1;
  localparam int SqW = 2 * SampleWidth;

  typedef enum logic [2:0] {
    M_CLEAR, M_RUN, M_WALK_RD, M_WALK_WAIT, M_WALK_CALC, M_WALK_WR
  } mstate_t;

  logic [PowerWidth+CountWidth-1:0] stat_mem [MaxChannels];
  logic [RmsWidth-1:0]              rms_mem  [MaxChannels];

  mstate_t                          state;
  logic [ChW:0]                     walk;
  logic [PowerWidth+CountWidth-1:0] rd_data;
  logic [RmsWidth-1:0]              rms_rd;
  logic [ChW-1:0]                   rd_addr;
  logic                             upd_valid;
  logic [ChW-1:0]                   upd_ch;
  logic [SqW-1:0]                   upd_sq;
  logic                             wr_fwd_valid;
  logic [ChW-1:0]                   wr_fwd_ch;
  logic [PowerWidth+CountWidth-1:0] wr_fwd_data;
  logic [PowerWidth+CountWidth-1:0] cur;
  logic [PowerWidth-1:0]            cur_sum;
  logic [CountWidth-1:0]            cur_cnt;
  logic [PowerWidth:0]              sum_add;
  logic [PowerWidth+CountWidth-1:0] new_entry;
  logic                             pend_eos;
  logic                             ds_start;
  logic                             ds_done;
  logic [RmsWidth-1:0]              ds_root;
  logic signed [SqW-1:0]            sq_full;
  logic [ChW-1:0]                   walk_ch;
  logic                             wr_en;
  logic [ChW-1:0]                   wr_addr;

  assign walk_ch = walk[ChW-1:0];
  assign sq_full = smp_data * smp_data;
  assign rd_addr = (state == M_RUN) ? smp_ch : walk_ch;

  // Forward the value written last cycle when the same channel is read back.
  assign cur     = (wr_fwd_valid && wr_fwd_ch == upd_ch) ? wr_fwd_data : rd_data;
  assign cur_sum = cur[PowerWidth+CountWidth-1:CountWidth];
  assign cur_cnt = cur[CountWidth-1:0];
  assign sum_add = {1'b0, cur_sum} + (PowerWidth+1)'(upd_sq);
  assign new_entry = {sum_add[PowerWidth] ? {PowerWidth{1'b1}} : sum_add[PowerWidth-1:0],
                      cur_cnt + CountWidth'(1)};
  assign wr_en   = upd_valid && (cur_cnt < stats_limit);
  assign wr_addr = (state == M_CLEAR) ? walk_ch : upd_ch;

  always_ff @(posedge clk) begin
    rd_data <= stat_mem[rd_addr];
    rms_rd  <= rms_mem[rd_addr];
    if (state == M_CLEAR) begin
      stat_mem[wr_addr] <= '0;
      rms_mem[wr_addr]  <= RMS_RESET;
    end else if (wr_en) begin
      stat_mem[wr_addr] <= new_entry;
    end else if (state == M_WALK_WR) begin
      rms_mem[walk_ch] <= ds_root;
    end
  end

  assign rms_out = rms_rd;

  tbq_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .dividend (cur_sum),
    .divisor  (cur_cnt),
    .done     (ds_done),
    .root     (ds_root)
  );

  always_comb begin
    ds_start = 1'b0;
    if (state == M_WALK_CALC && !pend_eos) begin
      ds_start = (rd_data[CountWidth-1:0] != '0) && (rd_data[CountWidth-1:0] <= stats_limit);
    end
  end

  always_ff @(posedge clk) begin
    upd_sq       <= SqW'(sq_full);
    upd_ch       <= smp_ch;
    wr_fwd_ch    <= upd_ch;
    wr_fwd_data  <= new_entry;
    if (rst) begin
      state        <= M_CLEAR;
      walk         <= '0;
      upd_valid    <= 1'b0;
      wr_fwd_valid <= 1'b0;
      pend_eos     <= 1'b0;
    end else begin
      upd_valid    <= smp_valid && state == M_RUN;
      wr_fwd_valid <= wr_en;
      case (state)
        M_CLEAR: begin
          if (walk == (ChW+1)'(MaxChannels - 1)) begin
            walk  <= '0;
            state <= M_RUN;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        M_RUN: begin
          if (smp_valid && smp_eos) begin
            pend_eos <= 1'b1;
            walk     <= '0;
            state    <= M_WALK_RD;
          end
        end
        M_WALK_RD: begin
          // The last sample's write lands this cycle; the read follows it.
          pend_eos <= 1'b0;
          state    <= M_WALK_WAIT;
        end
        M_WALK_WAIT: state <= M_WALK_CALC;
        M_WALK_CALC: begin
          if (ds_start) begin
            state <= M_WALK_WR;
          end else if (walk + 1'b1 >= {1'b0, active_n}) begin
            state <= M_RUN;
          end else begin
            walk  <= walk + 1'b1;
            state <= M_WALK_WAIT;
          end
        end
        M_WALK_WR: begin
          if (ds_done) begin
            if (walk + 1'b1 >= {1'b0, active_n}) begin
              state <= M_RUN;
            end else begin
              walk  <= walk + 1'b1;
              state <= M_WALK_WAIT;
            end
          end
        end
        default: state <= M_RUN;
      endcase
    end
  end

  assign stat.busy  = (state != M_RUN);
  assign stat.ready = (state == M_RUN);

endmodule

// ===== hw/rtl/two_bit_quantizer_packer.sv =====
// Two-bit quantizer and word packer with adaptive per-channel thresholds.
//
// Samples arrive on the in_ch sink, one word per cycle, in time-major,
// channel-minor order; the channel comes from an internal counter. Each
// sample's channel rms is read from memory at the edge that takes it, and
// the sample is compared and packed in the following cycle. Every 32 samples
// a 64-bit word of codes leaves on out_ch from the output register, with a
// last-in-packet flag in bit 64 set on the final word of a packet.
// The output register holds the word while the receiver stalls, and input
// is refused until it is taken.
// Throughput is one sample per cycle while neither a walk nor the output
// stalls. A sample flagged end_of_slice starts a walk over the active
// channels; each channel with statistics runs a sequential divide and then
// a sequential square root, and input stalls for the whole walk.
// After reset the block first clears its statistics
// memories before it takes the first sample. Configuration is written on
// cfg_we, cfg_index and cfg_data.
module two_bit_quantizer_packer
  import tbq_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDefault,
  parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  tbq_if.sink                      in_ch,
  tbq_if.source                    out_ch
);

  localparam int ChW  = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
  localparam int CmpW = SAMPLE_WIDTH + 18;

  logic [15:0]             threshold_scale;
  logic [2:0]              channels_log2;
  logic [CountWidth-1:0]   stats_limit;
  logic [10:0]             words_per_packet;
  logic [ChW:0]            active_n;
  logic [ChW:0]            channel_index;
  logic [ChW:0]            channel_index_next;
  logic [4:0]              slot_index;
  logic [4:0]              slot_index_q;
  logic [63:0]             word_accum;
  logic [9:0]              packet_word_count;
  logic [10:0]             wpp;
  logic                    accept;
  logic                    q_valid;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic                    q_last_slot;
  logic [1:0]              code;
  logic signed [CmpW-1:0]  scaled;
  logic signed [CmpW-1:0]  thr;
  logic [RmsWidth-1:0]     rms;
  tbq_stat_t               stat;
  logic [ChW-1:0]          smp_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_scale  <= 16'd4096;
      channels_log2    <= '0;
      stats_limit      <= {CountWidth{1'b1}};
      words_per_packet <= PACKET_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD_SCALE:  threshold_scale  <= cfg_data[15:0];
        REG_CHANNELS_LOG2:    channels_log2    <= cfg_data[2:0];
        REG_STATS_LIMIT:      stats_limit      <= cfg_data[CountWidth-1:0];
        REG_WORDS_PER_PACKET: words_per_packet <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ((32'd1 << channels_log2) > 32'(MAX_CHANNELS)) begin
      active_n = (ChW+1)'(MAX_CHANNELS);
    end else begin
      active_n = (ChW+1)'(32'd1 << channels_log2);
    end
    if (words_per_packet == 11'd0) begin
      wpp = 11'd1;
    end else if (words_per_packet > PACKET_MAX) begin
      wpp = PACKET_MAX;
    end else begin
      wpp = words_per_packet;
    end
    channel_index_next = (channel_index + 1'b1 >= active_n) ? '0 : channel_index + 1'b1;
    smp_ch = (channel_index >= (ChW+1)'(MAX_CHANNELS)) ? '0 : channel_index[ChW-1:0];
  end

  // A sample is taken only when no finished word waits in the output register.
  assign in_ch.ready = stat.ready && !(out_ch.valid && !out_ch.ready)
                       && !(q_valid && q_last_slot && out_ch.valid);
  assign accept = in_ch.valid && in_ch.ready;

  tbq_stats #(
    .MaxChannels (MAX_CHANNELS),
    .SampleWidth (SAMPLE_WIDTH)
  ) u_stats (
    .clk         (clk),
    .rst         (rst),
    .smp_valid   (accept),
    .smp_ch      (smp_ch),
    .smp_data    (in_ch.data[SAMPLE_WIDTH-1:0]),
    .smp_eos     (in_ch.data[SAMPLE_WIDTH]),
    .active_n    (active_n),
    .stats_limit (stats_limit),
    .rms_out     (rms),
    .stat        (stat)
  );

  assign scaled = CmpW'(q_sample) <<< 12;
  assign thr    = CmpW'($signed({1'b0, 32'(threshold_scale) * 32'(rms)}));

  always_comb begin
    if (scaled > thr) begin
      code = CODE_HIGH_POS;
    end else if (scaled < -thr) begin
      code = CODE_HIGH_NEG;
    end else if (q_sample > 0) begin
      code = CODE_LOW_POS;
    end else begin
      code = CODE_LOW_NEG;
    end
  end

  always_ff @(posedge clk) begin
    q_sample    <= in_ch.data[SAMPLE_WIDTH-1:0];
    q_last_slot <= (slot_index == LAST_SLOT);
    if (q_valid) begin
      word_accum[2*slot_index_q +: 2] <= code;
    end
    if (rst) begin
      q_valid           <= 1'b0;
      channel_index     <= '0;
      slot_index        <= '0;
      packet_word_count <= '0;
      out_ch.valid      <= 1'b0;
    end else begin
      q_valid <= accept;
      if (accept) begin
        channel_index <= channel_index_next;
        slot_index    <= slot_index + 5'd1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (q_valid && q_last_slot) begin
        out_ch.valid <= 1'b1;
        out_ch.data  <= {(11'(packet_word_count) + 11'd1) >= wpp, code, word_accum[61:0]};
        if ((11'(packet_word_count) + 11'd1) >= wpp) begin
          packet_word_count <= '0;
        end else begin
          packet_word_count <= packet_word_count + 10'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_index_q <= slot_index;
    end
  end

endmodule

// ===== hw/rtl/tbq_checker.sv =====
// Port-level checker for the quantizer and packer, bound to the top level.
module tbq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [64:0] out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_no_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // The statistics memories are being cleared straight after reset.
  a_no_reset_in: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind two_bit_quantizer_packer tbq_checker u_tbq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
